>>> rtl/core/mat_pkg.sv
// Shared types and codes for the compacting MAC address table.
package mat_pkg;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SLEEP  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNCHANGED = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] mac_address;
        logic              sleep_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count_out;
    } t_resp;

    // Per-cell command issued by the table controller.
    typedef struct packed {
        logic cmp_en;    // capture a fresh match result
        logic held;      // cell lies below the entry count
        logic load;      // take the new address, marked awake
        logic shift;     // take the contents of the next cell up
        logic set_flag;  // overwrite the sleep flag
    } t_cell_cmd;

    // What a cell shows to the controller and to its lower neighbor.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              flag;
        logic              match;
    } t_cell_out;

endpackage

>>> rtl/core/mat_cell.sv
// One table cell: an address, its sleep flag and a registered match bit.
module mat_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mat_pkg::t_cell_cmd              i_cmd,
    input  logic [mat_pkg::ADDR_W-1:0]      i_cmp_addr,
    input  logic [mat_pkg::ADDR_W-1:0]      i_new_addr,
    input  logic                            i_flag_val,
    input  logic [mat_pkg::ADDR_W-1:0]      i_next_addr,
    input  logic                            i_next_flag,
    output mat_pkg::t_cell_out              o_cell
);

    logic [mat_pkg::ADDR_W-1:0] r_addr;
    logic                       r_flag;
    logic                       r_match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_new_addr;
            r_flag <= 1'b0;
        end else if (i_cmd.shift) begin
            r_addr <= i_next_addr;
            r_flag <= i_next_flag;
        end else if (i_cmd.set_flag) begin
            r_flag <= i_flag_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmd.cmp_en) begin
            r_match <= i_cmd.held && (r_addr == i_cmp_addr);
        end
    end

    assign o_cell.addr  = r_addr;
    assign o_cell.flag  = r_flag;
    assign o_cell.match = r_match;

endmodule

>>> rtl/core/mac_address_table.sv
// Top level of the compacting MAC address table: controller and chain of cells.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_ready    i_in_data  (mat_pkg::t_req)
//   result    out        o_out_valid / i_out_ready  o_out_data (mat_pkg::t_resp)
//
// For each request, every cell compares its address with the request at the
// accepting edge and registers a match bit; in the execute state the
// controller then resolves the status and updates the cells in place.
// A delete moves every cell above the hit one place down along the chain, over the hit,
// so the table stays ordered without any search loop.
// Reset (synchronous, active low) empties the table by clearing the entry count
// only; cell contents are never read above the count, so no clearing pass runs.
// The result sits in an output register, so a new request is accepted while a
// result waits; the update stalls only if the previous result is still untaken.
module mac_address_table #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mat_pkg::t_req    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mat_pkg::t_resp   o_out_data
);

    // Index and count widths follow from the table depth.
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    mat_pkg::t_req               r_req;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid;
    mat_pkg::t_resp              r_out_data, n_out_data;

    mat_pkg::t_cell_cmd          cmd   [MAX_ENTRIES];
    mat_pkg::t_cell_out          cells [MAX_ENTRIES];
    logic [mat_pkg::ADDR_W-1:0]  next_addr [MAX_ENTRIES];
    logic                        next_flag [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]      match_vec;

    logic                        accept;
    logic                        exec_go;
    logic                        hit;
    logic                        hit_flag;
    logic [IDX_W-1:0]            hit_idx;
    logic                        full;
    logic                        do_insert;
    logic                        do_delete;
    logic                        do_sleep;
    logic [31:0]                 count_ext;

    // Requests are taken only between operations; the result register keeps
    // the output side decoupled.
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Matches are unique below the count because inserts reject duplicates,
    // so the hit index and its flag are plain OR reductions.
    always_comb begin
        hit      = 1'b0;
        hit_flag = 1'b0;
        hit_idx  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit      = hit | cells[i].match;
            hit_flag = hit_flag | (cells[i].match & cells[i].flag);
            hit_idx  = hit_idx | (cells[i].match ? IDX_W'(i) : '0);
        end
    end

    assign full      = (r_count == CNT_W'(MAX_ENTRIES));
    assign do_insert = exec_go && (r_req.operation == mat_pkg::OP_INSERT) && !full && !hit;
    assign do_delete = exec_go && (r_req.operation == mat_pkg::OP_DELETE) && hit;
    assign do_sleep  = exec_go && (r_req.operation == mat_pkg::OP_SLEEP) && hit
                       && (hit_flag != r_req.sleep_value);

    // Result status and the count after this request.
    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_delete) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_ext = 32'(n_count);

    always_comb begin
        n_out_data.entry_count_out = count_ext[mat_pkg::COUNT_W-1:0];
        case (r_req.operation)
            mat_pkg::OP_LOOKUP: begin
                n_out_data.status = hit ? mat_pkg::ST_FOUND : mat_pkg::ST_NOT_FOUND;
            end
            mat_pkg::OP_INSERT: begin
                if (full) begin
                    n_out_data.status = mat_pkg::ST_FULL;
                end else if (hit) begin
                    n_out_data.status = mat_pkg::ST_PRESENT;
                end else begin
                    n_out_data.status = mat_pkg::ST_DONE;
                end
            end
            mat_pkg::OP_DELETE: begin
                n_out_data.status = hit ? mat_pkg::ST_DONE : mat_pkg::ST_NOT_FOUND;
            end
            mat_pkg::OP_SLEEP: begin
                if (!hit) begin
                    n_out_data.status = mat_pkg::ST_NOT_FOUND;
                end else if (hit_flag == r_req.sleep_value) begin
                    n_out_data.status = mat_pkg::ST_UNCHANGED;
                end else begin
                    n_out_data.status = mat_pkg::ST_DONE;
                end
            end
            default: begin
                n_out_data.status = mat_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
        end
        if (exec_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The chain: each cell hears the request and takes data from the cell above.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g + 1 < MAX_ENTRIES) begin : g_link
            assign next_addr[g] = cells[g+1].addr;
            assign next_flag[g] = cells[g+1].flag;
        end else begin : g_end
            assign next_addr[g] = '0;
            assign next_flag[g] = 1'b0;
        end

        assign cmd[g].cmp_en   = accept;
        assign cmd[g].held     = (CNT_W'(g) < r_count);
        assign cmd[g].load     = do_insert && (CNT_W'(g) == r_count);
        assign cmd[g].shift    = do_delete && (IDX_W'(g) >= hit_idx);
        assign cmd[g].set_flag = do_sleep && cells[g].match;

        assign match_vec[g] = cells[g].match;

        mat_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd[g]),
            .i_cmp_addr  (i_in_data.mac_address),
            .i_new_addr  (r_req.mac_address),
            .i_flag_val  (r_req.sleep_value),
            .i_next_addr (next_addr[g]),
            .i_next_flag (next_flag[g]),
            .o_cell      (cells[g])
        );
    end

    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // At most one held cell may match while a request is resolved.
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(match_vec))
        else $error("match vector not unique");

    // A successful delete shrinks the table by one.
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_delete |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not decrement count");

    // A successful insert grows the table by one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not increment count");

    // No request is accepted while one is being resolved.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("request accepted during execution");

endmodule
